// ----- sv/pctx_pkg.sv -----
// ---------------------------------------------------------------------------
// pctx_pkg
// Field widths, register indexes and reset values of the perspective crawl
// texel address block.
// ---------------------------------------------------------------------------
`default_nettype none

package pctx_pkg;

  // Request and result fields
  localparam int PIX_X_W    = 9;
  localparam int PIX_Y_W    = 8;
  localparam int PHASE_W    = 20;
  localparam int PHASE_FRAC = 8;
  localparam int SRC_W      = 12;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int HORIZON_W  = 8;
  localparam int DEPTH_W    = 16;
  localparam int STRIP_W    = 12;

  localparam logic [CFG_IDX_W-1:0] REG_HORIZON_ROW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERSP_DEPTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRIP_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRIP_HEIGHT = 2'd3;

  localparam logic [HORIZON_W-1:0] RST_HORIZON_ROW  = 8'd42;
  localparam logic [DEPTH_W-1:0]   RST_PERSP_DEPTH  = 16'd3600;
  localparam logic [STRIP_W-1:0]   RST_STRIP_WIDTH  = 12'd320;
  localparam logic [STRIP_W-1:0]   RST_STRIP_HEIGHT = 12'd384;

  // Divisor of the divider chain is the row distance
  localparam int DIV_W = PIX_Y_W;

endpackage

`default_nettype wire

// ----- sv/pctx_pix_if.sv -----
// ---------------------------------------------------------------------------
// pctx_pix_if
// Pixel request channel: screen column, screen row and crawl phase.
// ---------------------------------------------------------------------------
`default_nettype none

interface pctx_pix_if;
  logic                          valid;
  logic                          ready;
  logic [pctx_pkg::PIX_X_W-1:0]  pixel_x;
  logic [pctx_pkg::PIX_Y_W-1:0]  pixel_y;
  logic [pctx_pkg::PHASE_W-1:0]  phase;

  modport source (output valid, pixel_x, pixel_y, phase, input ready);
  modport sink   (input valid, pixel_x, pixel_y, phase, output ready);
endinterface

`default_nettype wire

// ----- sv/pctx_res_if.sv -----
// ---------------------------------------------------------------------------
// pctx_res_if
// Result channel: draw flag and strip column and row to sample.
// ---------------------------------------------------------------------------
`default_nettype none

interface pctx_res_if;
  logic                        valid;
  logic                        ready;
  logic                        draw;
  logic [pctx_pkg::SRC_W-1:0]  source_x;
  logic [pctx_pkg::SRC_W-1:0]  source_y;

  modport source (output valid, draw, source_x, source_y, input ready);
  modport sink   (input valid, draw, source_x, source_y, output ready);
endinterface

`default_nettype wire

// ----- sv/pctx_cfg_if.sv -----
// ---------------------------------------------------------------------------
// pctx_cfg_if
// Configuration write channel: register index and write data.
// ---------------------------------------------------------------------------
`default_nettype none

interface pctx_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pctx_pkg::CFG_IDX_W-1:0]   index;
  logic [pctx_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- sv/pctx_div_cell.sv -----
// ---------------------------------------------------------------------------
// pctx_div_cell
// One restoring division step on two dividends that share one divisor.
// Each cell retires one quotient bit of each and hands on to the next.
// ---------------------------------------------------------------------------
`default_nettype none

module pctx_div_cell #(
  parameter int NUM_W  = 25,
  parameter int SIDE_W = 22
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       vld_i,
  input  wire logic [pctx_pkg::DIV_W-1:0] den_i,
  input  wire logic [pctx_pkg::DIV_W-1:0] rem_a_i,
  input  wire logic [NUM_W-1:0]           acc_a_i,
  input  wire logic [pctx_pkg::DIV_W-1:0] rem_b_i,
  input  wire logic [NUM_W-1:0]           acc_b_i,
  input  wire logic [SIDE_W-1:0]          side_i,
  output logic                            vld_o,
  output logic [pctx_pkg::DIV_W-1:0]      den_o,
  output logic [pctx_pkg::DIV_W-1:0]      rem_a_o,
  output logic [NUM_W-1:0]                acc_a_o,
  output logic [pctx_pkg::DIV_W-1:0]      rem_b_o,
  output logic [NUM_W-1:0]                acc_b_o,
  output logic [SIDE_W-1:0]               side_o
);

  localparam int DW = pctx_pkg::DIV_W;

  logic [DW:0]       try_a;
  logic [DW:0]       try_b;
  logic              ge_a;
  logic              ge_b;
  logic [DW:0]       diff_a;
  logic [DW:0]       diff_b;
  logic [DW-1:0]     rem_a_nxt;
  logic [DW-1:0]     rem_b_nxt;
  logic [NUM_W-1:0]  acc_a_nxt;
  logic [NUM_W-1:0]  acc_b_nxt;

  logic              vld_r;
  logic [DW-1:0]     den_r;
  logic [DW-1:0]     rem_a_r;
  logic [DW-1:0]     rem_b_r;
  logic [NUM_W-1:0]  acc_a_r;
  logic [NUM_W-1:0]  acc_b_r;
  logic [SIDE_W-1:0] side_r;

  always_comb begin
    // Bring down the next dividend bit, subtract when it fits
    try_a     = {rem_a_i, acc_a_i[NUM_W-1]};
    try_b     = {rem_b_i, acc_b_i[NUM_W-1]};
    ge_a      = try_a >= {1'b0, den_i};
    ge_b      = try_b >= {1'b0, den_i};
    diff_a    = try_a - {1'b0, den_i};
    diff_b    = try_b - {1'b0, den_i};
    rem_a_nxt = ge_a ? diff_a[DW-1:0] : try_a[DW-1:0];
    rem_b_nxt = ge_b ? diff_b[DW-1:0] : try_b[DW-1:0];
    acc_a_nxt = {acc_a_i[NUM_W-2:0], ge_a};
    acc_b_nxt = {acc_b_i[NUM_W-2:0], ge_b};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r   <= den_i;
      rem_a_r <= rem_a_nxt;
      rem_b_r <= rem_b_nxt;
      acc_a_r <= acc_a_nxt;
      acc_b_r <= acc_b_nxt;
      side_r  <= side_i;
    end
  end

  assign vld_o   = vld_r;
  assign den_o   = den_r;
  assign rem_a_o = rem_a_r;
  assign rem_b_o = rem_b_r;
  assign acc_a_o = acc_a_r;
  assign acc_b_o = acc_b_r;
  assign side_o  = side_r;

endmodule

`default_nettype wire

// ----- sv/pctx_div_chain.sv -----
// ---------------------------------------------------------------------------
// pctx_div_chain
// Row of division cells, one per quotient bit. Gives two quotients by the
// same divisor, one new pair per cycle while en is high.
// ---------------------------------------------------------------------------
`default_nettype none

module pctx_div_chain #(
  parameter int NUM_W  = 25,
  parameter int SIDE_W = 22
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       vld_i,
  input  wire logic [pctx_pkg::DIV_W-1:0] den_i,
  input  wire logic [NUM_W-1:0]           num_a_i,
  input  wire logic [NUM_W-1:0]           num_b_i,
  input  wire logic [SIDE_W-1:0]          side_i,
  output logic                            vld_o,
  output logic [NUM_W-1:0]                quo_a_o,
  output logic [NUM_W-1:0]                quo_b_o,
  output logic [SIDE_W-1:0]               side_o
);

  localparam int DW = pctx_pkg::DIV_W;

  logic              vld   [0:NUM_W];
  logic [DW-1:0]     den   [0:NUM_W];
  logic [DW-1:0]     rem_a [0:NUM_W];
  logic [DW-1:0]     rem_b [0:NUM_W];
  logic [NUM_W-1:0]  acc_a [0:NUM_W];
  logic [NUM_W-1:0]  acc_b [0:NUM_W];
  logic [SIDE_W-1:0] side  [0:NUM_W];

  assign vld[0]   = vld_i;
  assign den[0]   = den_i;
  assign rem_a[0] = '0;
  assign rem_b[0] = '0;
  assign acc_a[0] = num_a_i;
  assign acc_b[0] = num_b_i;
  assign side[0]  = side_i;

  for (genvar i = 0; i < NUM_W; i++) begin : g_cell
    pctx_div_cell #(
      .NUM_W  (NUM_W),
      .SIDE_W (SIDE_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .vld_i   (vld[i]),
      .den_i   (den[i]),
      .rem_a_i (rem_a[i]),
      .acc_a_i (acc_a[i]),
      .rem_b_i (rem_b[i]),
      .acc_b_i (acc_b[i]),
      .side_i  (side[i]),
      .vld_o   (vld[i+1]),
      .den_o   (den[i+1]),
      .rem_a_o (rem_a[i+1]),
      .acc_a_o (acc_a[i+1]),
      .rem_b_o (rem_b[i+1]),
      .acc_b_o (acc_b[i+1]),
      .side_o  (side[i+1])
    );
  end

  assign vld_o   = vld[NUM_W];
  assign quo_a_o = acc_a[NUM_W];
  assign quo_b_o = acc_b[NUM_W];
  assign side_o  = side[NUM_W];

endmodule

`default_nettype wire

// ----- sv/perspective_crawl_texel_address.sv -----
// ---------------------------------------------------------------------------
// perspective_crawl_texel_address
// Maps each screen pixel below the horizon onto the receding text strip and
// returns the strip column and row to sample, or no draw. One pixel request
// is taken per clock unless the pipe stalls; a result passes the registers
// of stages A and B, the NUM_W cells of the divider chain, stage C and the
// output register, where NUM_W is the quotient width of the chain (24 cells
// with the default parameters). Both divisions by the row distance run side
// by side in that chain, one quotient bit per cell. The block keeps taking
// requests while a result waits at the output, and stalls only once the
// last pipeline stage also holds a result. Configuration writes are taken in
// every cycle and must only be issued while no request is in flight.
`default_nettype none

module perspective_crawl_texel_address #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 200,
  parameter int FRAC_BITS     = 8
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pctx_pix_if.sink   in_pix,
  pctx_res_if.source out_res,
  pctx_cfg_if.sink   cfg_wr
);

  localparam int CEN    = SCREEN_WIDTH / 2;
  localparam int DXW    = $clog2(CEN + 1);
  localparam int KW     = DXW + 1;
  localparam int BW     = $clog2(SCREEN_HEIGHT + 1);
  localparam int PHF_W  = pctx_pkg::PHASE_W + FRAC_BITS - pctx_pkg::PHASE_FRAC;
  localparam int MQW    = DXW + BW;
  localparam int PKW    = KW + BW + 1;
  localparam int PNW    = pctx_pkg::STRIP_W + pctx_pkg::DIV_W;
  localparam int LAGW   = pctx_pkg::DEPTH_W + FRAC_BITS;
  localparam int NUM_W  = (LAGW > MQW + FRAC_BITS) ? LAGW : MQW + FRAC_BITS;
  localparam int SIDE_W = PHF_W + 2;
  localparam int EW     = NUM_W + 2;
  localparam int DW     = pctx_pkg::DIV_W;
  localparam int SW     = pctx_pkg::SRC_W;

  // Configuration registers
  logic [pctx_pkg::HORIZON_W-1:0] horizon_row_r;
  logic [pctx_pkg::DEPTH_W-1:0]   persp_depth_r;
  logic [pctx_pkg::STRIP_W-1:0]   strip_width_r;
  logic [pctx_pkg::STRIP_W-1:0]   strip_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      horizon_row_r  <= pctx_pkg::RST_HORIZON_ROW;
      persp_depth_r  <= pctx_pkg::RST_PERSP_DEPTH;
      strip_width_r  <= pctx_pkg::RST_STRIP_WIDTH;
      strip_height_r <= pctx_pkg::RST_STRIP_HEIGHT;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        pctx_pkg::REG_HORIZON_ROW:  horizon_row_r  <= cfg_wr.data[pctx_pkg::HORIZON_W-1:0];
        pctx_pkg::REG_PERSP_DEPTH:  persp_depth_r  <= cfg_wr.data[pctx_pkg::DEPTH_W-1:0];
        pctx_pkg::REG_STRIP_WIDTH:  strip_width_r  <= cfg_wr.data[pctx_pkg::STRIP_W-1:0];
        pctx_pkg::REG_STRIP_HEIGHT: strip_height_r <= cfg_wr.data[pctx_pkg::STRIP_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_wr.ready = 1'b1;

  // Flow control: the output register loads when free or taken, the rest
  // of the pipe advances as well whenever its last stage holds nothing.
  logic out_valid_r;
  logic vc_r;
  logic out_load;
  logic en;

  assign out_load     = out_res.ready || !out_valid_r;
  assign en           = out_load || !vc_r;
  assign in_pix.ready = en;

  // Stage A: screen tests, row distances, column offset
  logic                       a_skip_nxt;
  logic                       a_neg_nxt;
  logic [DXW-1:0]             a_adx_nxt;
  logic [KW-1:0]              a_k_nxt;
  logic [DW-1:0]              a_d_nxt;
  logic [BW-1:0]              a_b_nxt;
  logic [pctx_pkg::PHASE_W+FRAC_BITS-1:0] ph_wide;

  always_comb begin
    a_skip_nxt = ({1'b0, in_pix.pixel_y} <= {1'b0, horizon_row_r})
              || (32'(in_pix.pixel_y) >= 32'(SCREEN_HEIGHT))
              || (32'(in_pix.pixel_x) >= 32'(SCREEN_WIDTH));
    a_neg_nxt  = 32'(in_pix.pixel_x) < 32'(CEN);
    a_adx_nxt  = a_neg_nxt ? DXW'(32'(CEN) - 32'(in_pix.pixel_x))
                           : DXW'(32'(in_pix.pixel_x) - 32'(CEN));
    // Pixel lies inside the half-width when k * 2B <= W * d
    a_k_nxt    = a_neg_nxt ? KW'(a_adx_nxt) : KW'(a_adx_nxt) + KW'(1);
    a_d_nxt    = in_pix.pixel_y - horizon_row_r;
    a_b_nxt    = BW'(32'(SCREEN_HEIGHT) - 32'(horizon_row_r));
    ph_wide    = {in_pix.phase, {FRAC_BITS{1'b0}}};
  end

  logic              va_r;
  logic              a_ok_r;
  logic              a_neg_r;
  logic [DXW-1:0]    a_adx_r;
  logic [KW-1:0]     a_k_r;
  logic [DW-1:0]     a_d_r;
  logic [BW-1:0]     a_b_r;
  logic [PHF_W-1:0]  a_phf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_ok_r  <= !a_skip_nxt;
      a_neg_r <= a_neg_nxt;
      a_adx_r <= a_adx_nxt;
      a_k_r   <= a_k_nxt;
      a_d_r   <= a_d_nxt;
      a_b_r   <= a_b_nxt;
      a_phf_r <= ph_wide[pctx_pkg::PHASE_W+FRAC_BITS-1:pctx_pkg::PHASE_FRAC];
    end
  end

  // Stage B: products
  logic              vb_r;
  logic              b_ok_r;
  logic              b_neg_r;
  logic [DW-1:0]     b_d_r;
  logic [PHF_W-1:0]  b_phf_r;
  logic [MQW-1:0]    b_mulq_r;
  logic [PKW-1:0]    b_pk_r;
  logic [PNW-1:0]    b_pn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_ok_r   <= a_ok_r;
      b_neg_r  <= a_neg_r;
      b_d_r    <= a_d_r;
      b_phf_r  <= a_phf_r;
      b_mulq_r <= MQW'(a_adx_r) * MQW'(a_b_r);
      b_pk_r   <= PKW'(a_k_r) * PKW'({a_b_r, 1'b0});
      b_pn_r   <= PNW'(strip_width_r) * PNW'(a_d_r);
    end
  end

  // Divider chain: row lag and column offset, both over the row distance
  logic               b_in_range;
  logic [NUM_W-1:0]   num_a;
  logic [NUM_W-1:0]   num_b;
  logic [SIDE_W-1:0]  side_in;
  logic               ch_vld;
  logic [NUM_W-1:0]   ch_lag;
  logic [NUM_W-1:0]   ch_qmag;
  logic [SIDE_W-1:0]  ch_side;

  assign b_in_range = 32'(b_pk_r) <= 32'(b_pn_r);
  assign num_a      = NUM_W'({persp_depth_r, {FRAC_BITS{1'b0}}});
  assign num_b      = NUM_W'({b_mulq_r, {FRAC_BITS{1'b0}}});
  assign side_in    = {b_ok_r && b_in_range, b_neg_r, b_phf_r};

  pctx_div_chain #(
    .NUM_W  (NUM_W),
    .SIDE_W (SIDE_W)
  ) u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (vb_r),
    .den_i   (b_d_r),
    .num_a_i (num_a),
    .num_b_i (num_b),
    .side_i  (side_in),
    .vld_o   (ch_vld),
    .quo_a_o (ch_lag),
    .quo_b_o (ch_qmag),
    .side_o  (ch_side)
  );

  // Stage C: fixed-point source row and column
  logic [EW-1:0] half_w;
  logic [EW-1:0] c_syf_nxt;
  logic [EW-1:0] c_uf_nxt;

  always_comb begin
    half_w    = EW'(strip_width_r) << (FRAC_BITS - 1);
    c_syf_nxt = EW'(ch_side[PHF_W-1:0]) - EW'(ch_lag);
    c_uf_nxt  = ch_side[PHF_W] ? (half_w - EW'(ch_qmag)) : (half_w + EW'(ch_qmag));
  end

  logic          c_ok_r;
  logic [EW-1:0] c_syf_r;
  logic [EW-1:0] c_uf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= ch_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_ok_r  <= ch_side[PHF_W+1];
      c_syf_r <= c_syf_nxt;
      c_uf_r  <= c_uf_nxt;
    end
  end

  // Stage D: truncate toward zero and bound-check against the strip
  logic          sy_sign;
  logic          sx_sign;
  logic [EW-1:0] sy_mag;
  logic [EW-1:0] sx_mag;
  logic [EW-1:0] sy_ip;
  logic [EW-1:0] sx_ip;
  logic          sy_ok;
  logic          sx_ok;
  logic          draw_nxt;
  logic [SW-1:0] src_x_nxt;
  logic [SW-1:0] src_y_nxt;

  always_comb begin
    sy_sign   = c_syf_r[EW-1];
    sx_sign   = c_uf_r[EW-1];
    sy_mag    = sy_sign ? (~c_syf_r + EW'(1)) : c_syf_r;
    sx_mag    = sx_sign ? (~c_uf_r + EW'(1)) : c_uf_r;
    sy_ip     = sy_mag >> FRAC_BITS;
    sx_ip     = sx_mag >> FRAC_BITS;
    // A value just below zero truncates to row or column zero
    sy_ok     = sy_sign ? ((sy_ip == '0) && (strip_height_r != '0))
                        : (sy_ip < EW'(strip_height_r));
    sx_ok     = sx_sign ? ((sx_ip == '0) && (strip_width_r != '0))
                        : (sx_ip < EW'(strip_width_r));
    draw_nxt  = c_ok_r && sy_ok && sx_ok;
    src_y_nxt = (draw_nxt && !sy_sign) ? sy_ip[SW-1:0] : '0;
    src_x_nxt = (draw_nxt && !sx_sign) ? sx_ip[SW-1:0] : '0;
  end

  logic          out_draw_r;
  logic [SW-1:0] out_src_x_r;
  logic [SW-1:0] out_src_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_draw_r  <= draw_nxt;
      out_src_x_r <= src_x_nxt;
      out_src_y_r <= src_y_nxt;
    end
  end

  assign out_res.valid    = out_valid_r;
  assign out_res.draw     = out_draw_r;
  assign out_res.source_x = out_src_x_r;
  assign out_res.source_y = out_src_y_r;

endmodule

`default_nettype wire
